// File: rtl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ALT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define ALT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ALT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/alt_pkg.sv
// Types, character codes and classification functions of the assembly line tokenizer.
package alt_pkg;

   // Tokenizer phase within a line
   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_LABEL = 3'd1,
      PH_GAP1  = 3'd2,
      PH_CMD   = 3'd3,
      PH_GAP2  = 3'd4,
      PH_OPND  = 3'd5,
      PH_DONE  = 3'd6,
      PH_EMPTY = 3'd7
   } phase_type;

   // Character part codes
   localparam logic [1:0] PART_DROP    = 2'd0;
   localparam logic [1:0] PART_LABEL   = 2'd1;
   localparam logic [1:0] PART_COMMAND = 2'd2;
   localparam logic [1:0] PART_OPERAND = 2'd3;

   // Status codes
   localparam logic [2:0] ERR_OK           = 3'd0;
   localparam logic [2:0] ERR_LABEL_LONG   = 3'd1;
   localparam logic [2:0] ERR_NO_COMMAND   = 3'd2;
   localparam logic [2:0] ERR_MANY_OPNDS   = 3'd3;
   localparam logic [2:0] ERR_OPERAND_LONG = 3'd4;
   localparam logic [2:0] ERR_EMPTY_OPND   = 3'd5;
   localparam logic [2:0] ERR_UNCLOSED     = 3'd6;

   // Character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   // Per-line running state
   typedef struct packed {
      phase_type  phase;
      logic       in_quote;
      logic [3:0] label_length;
      logic [5:0] operand_length;
      logic [5:0] operand_count;
      logic [2:0] error_code;
      logic       label_seen;
      logic       quote_pair;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:          PH_START,
      in_quote:       1'b0,
      label_length:   4'd0,
      operand_length: 6'd0,
      operand_count:  6'd0,
      error_code:     ERR_OK,
      label_seen:     1'b0,
      quote_pair:     1'b0
   };

   // One result transaction
   typedef struct packed {
      logic [7:0] out_char;
      logic [1:0] part;
      logic [5:0] operand_index;
      logic       token_end;
      logic       line_done;
      logic       empty_line;
      logic [2:0] status;
   } result_type;

   // State after one character, with the result it produced
   typedef struct packed {
      state_type  st;
      result_type res;
   } step_type;

   // Result queue push control
   typedef struct packed {
      logic valid0;
      logic valid1;
   } push_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   // Operand character (not a separator outside quotes)
   function automatic step_type alt_take(input step_type si, input logic [7:0] c,
                                         input logic has_next, input logic [7:0] nx,
                                         input logic [5:0] operand_max);
      step_type so;
      logic     q;
      logic     counted;
      so = si;
      q  = (c == CH_QUOTE);
      // quotes that open or close a string are not counted
      counted = (si.st.in_quote && si.st.quote_pair) ? 1'b1 : !q;
      if (counted && (si.st.operand_length >= operand_max)) begin
         so.st.error_code = ERR_OPERAND_LONG;
         so.st.phase      = PH_DONE;
      end else begin
         if (counted) so.st.operand_length = si.st.operand_length + 6'd1;
         if (si.st.in_quote) begin
            if (si.st.quote_pair) so.st.quote_pair = 1'b0;
            else if (q && has_next && (nx == CH_QUOTE)) so.st.quote_pair = 1'b1;
            else if (q) so.st.in_quote = 1'b0;
         end else if (q) begin
            so.st.in_quote = 1'b1;
         end
         so.st.phase           = PH_OPND;
         so.res.part           = PART_OPERAND;
         so.res.operand_index  = si.st.operand_count;
         so.res.token_end      = !has_next || (!so.st.in_quote &&
                                 (is_blank(nx) || (nx == CH_SEMI) || (nx == CH_COMMA)));
      end
      return so;
   endfunction

   // Classify one character given the next one (if any)
   function automatic step_type alt_classify(input state_type s, input logic [7:0] c,
                                             input logic has_next, input logic [7:0] nx,
                                             input logic [3:0] label_max,
                                             input logic [5:0] operand_max);
      step_type so;
      logic     stop;
      logic     blank;
      logic     semi;
      so.st  = s;
      so.res = '{out_char: c, part: PART_DROP, operand_index: 6'd0, token_end: 1'b0,
                 line_done: 1'b0, empty_line: 1'b0, status: ERR_OK};
      stop  = !has_next || is_blank(nx) || (nx == CH_SEMI);
      blank = is_blank(c);
      semi  = (c == CH_SEMI);

      unique case (s.phase)
         PH_START, PH_LABEL: begin
            if (blank) begin
               so.st.phase = PH_GAP1;
            end else if (semi) begin
               if (s.phase == PH_LABEL) begin
                  so.st.error_code = ERR_NO_COMMAND;
                  so.st.phase      = PH_DONE;
               end else begin
                  so.st.phase = PH_EMPTY;
               end
            end else if (s.label_length >= label_max) begin
               so.st.error_code = ERR_LABEL_LONG;
               so.st.phase      = PH_DONE;
            end else begin
               so.st.label_length = s.label_length + 4'd1;
               so.st.label_seen   = 1'b1;
               so.st.phase        = PH_LABEL;
               so.res.part        = PART_LABEL;
               so.res.token_end   = stop;
            end
         end
         PH_GAP1, PH_CMD: begin
            if (blank) begin
               if (s.phase == PH_CMD) so.st.phase = PH_GAP2;
            end else if (semi) begin
               if (s.phase == PH_CMD) begin
                  so.st.phase = PH_DONE;
               end else if (s.label_seen) begin
                  so.st.error_code = ERR_NO_COMMAND;
                  so.st.phase      = PH_DONE;
               end else begin
                  so.st.phase = PH_EMPTY;
               end
            end else begin
               so.st.phase      = PH_CMD;
               so.res.part      = PART_COMMAND;
               so.res.token_end = stop;
            end
         end
         PH_GAP2: begin
            if (blank) begin
               so.st.phase = PH_GAP2;
            end else if (semi) begin
               so.st.phase = PH_DONE;
            end else if (c == CH_COMMA) begin
               so.st.error_code = ERR_EMPTY_OPND;
               so.st.phase      = PH_DONE;
            end else begin
               so.st.operand_length = 6'd0;
               so = alt_take(so, c, has_next, nx, operand_max);
            end
         end
         PH_OPND: begin
            if (s.in_quote) begin
               so = alt_take(so, c, has_next, nx, operand_max);
            end else if (c == CH_COMMA) begin
               so.st.operand_count = s.operand_count + 6'd1;
               if (so.st.operand_count >= operand_max) begin
                  so.st.error_code = ERR_MANY_OPNDS;
                  so.st.phase      = PH_DONE;
               end else if (stop || (nx == CH_COMMA)) begin
                  so.st.error_code = ERR_EMPTY_OPND;
                  so.st.phase      = PH_DONE;
               end else begin
                  so.st.operand_length = 6'd0;
               end
            end else if (blank || semi) begin
               so.st.phase = PH_DONE;
            end else begin
               so = alt_take(so, c, has_next, nx, operand_max);
            end
         end
         default: begin
            so.st.phase = s.phase;
         end
      endcase
      so.res.status = so.st.error_code;
      return so;
   endfunction

   // Line-end checks on the last character's result
   function automatic result_type alt_finish(input step_type si);
      result_type r;
      logic [2:0] err;
      logic       empty;
      r   = si.res;
      err = si.st.error_code;
      if (err == ERR_OK) begin
         if ((si.st.phase == PH_LABEL) || ((si.st.phase == PH_GAP1) && si.st.label_seen))
            err = ERR_NO_COMMAND;
         else if ((si.st.phase == PH_OPND) && si.st.in_quote)
            err = ERR_UNCLOSED;
      end
      empty = (err == ERR_OK) && ((si.st.phase == PH_START) || (si.st.phase == PH_EMPTY) ||
              ((si.st.phase == PH_GAP1) && !si.st.label_seen));
      r.line_done  = 1'b1;
      r.empty_line = empty;
      r.status     = err;
      return r;
   endfunction

endpackage

// File: rtl/alt_queue.sv
// Four-entry result queue: takes up to two results per cycle, hands out one.
`include "assert_macros.svh"

module alt_queue (
   input  logic                clock,
   input  logic                reset,
   input  alt_pkg::push_type   push,
   input  alt_pkg::result_type push_data0,
   input  alt_pkg::result_type push_data1,
   output logic                space_ok,
   output logic                pop_valid,
   input  logic                pop_ready,
   output alt_pkg::result_type pop_data
);
   import alt_pkg::*;

   localparam int DEPTH = 4;

   result_type  entry_ff [DEPTH];
   logic [1:0]  head_ff, head_in;
   logic [1:0]  tail_ff, tail_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  push_count;
   logic        pop;

   // Room for the two results one transaction may cause
   assign space_ok   = (count_ff <= 3'd2);
   assign pop_valid  = (count_ff != 3'd0);
   assign pop_data   = entry_ff[head_ff];
   assign pop        = pop_valid && pop_ready;
   assign push_count = {1'b0, push.valid0} + {1'b0, push.valid1};

   always_comb begin
      head_in  = pop ? head_ff + 2'd1 : head_ff;
      tail_in  = tail_ff + push_count;
      count_in = count_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 2'd0;
         tail_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push.valid0) entry_ff[tail_ff] <= push_data0;
      if (push.valid1) entry_ff[tail_ff + 2'd1] <= push_data1;
   end

   `ALT_ASSERT_ALWAYS(a_count_range, count_ff <= 3'(DEPTH), "queue count above depth")
   `ALT_ASSERT_IMPL(a_push_room, push.valid0 || push.valid1, count_ff <= 3'd2, "push into full queue")
   `ALT_ASSERT_IMPL(a_push_order, push.valid1, push.valid0, "second push slot used alone")

endmodule

// File: rtl/assembly_line_tokenizer.sv
// Top level of the assembly line tokenizer: character classifier and result queue.
//
// Takes one source character per transaction and returns, one character late, its
// classification as label, command or operand character, with token ends and error
// status. A transaction gives no result for the first character of a line unless it
// carries tlast, one result for each later character, and two results for a later
// transaction marked with tlast (the held character and the last one). The classifier
// accepts one character every clock cycle; it is held off only when the four-entry
// result queue cannot take two more results, so the sustained rate is one character
// per cycle while the consumer takes results at least as fast as they come. Results
// are registered in the result queue before they appear on rsp_.
`include "assert_macros.svh"

module assembly_line_tokenizer #(
   parameter int LABEL_MAX   = 8,
   parameter int OPERAND_MAX = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_char, [13:8] operand_index,
                                    // [14] token_end, [15] empty_line, [18:16] status
   output logic [1:0]  rsp_tuser,   // part
   output logic        rsp_tlast    // line_done
);
   import alt_pkg::*;

   localparam logic [3:0] LABEL_LIMIT   = 4'(LABEL_MAX);
   localparam logic [5:0] OPERAND_LIMIT = 6'(OPERAND_MAX);

   state_type  state_ff, state_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;
   logic       accept;
   step_type   step_held;
   step_type   step_last;
   state_type  state_mid;
   result_type final_res;
   push_type   push;
   result_type push_data0;
   result_type push_data1;
   result_type rsp_res;

   assign accept = req_tvalid && req_tready;

   // Held character, decided with the incoming one as lookahead
   assign step_held = alt_classify(state_ff, held_char_ff, 1'b1, req_tdata,
                                   LABEL_LIMIT, OPERAND_LIMIT);
   assign state_mid = held_valid_ff ? step_held.st : state_ff;

   // Incoming character as the last of its line
   assign step_last = alt_classify(state_mid, req_tdata, 1'b0, 8'h00,
                                   LABEL_LIMIT, OPERAND_LIMIT);
   assign final_res = alt_finish(step_last);

   // Results of this transaction, in order
   always_comb begin
      push.valid0 = accept && (held_valid_ff || req_tlast);
      push.valid1 = accept && held_valid_ff && req_tlast;
      push_data0  = held_valid_ff ? step_held.res : final_res;
      push_data1  = final_res;
   end

   // Next running state: line end returns everything to the line start
   always_comb begin
      state_in      = state_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      if (accept) begin
         if (req_tlast) begin
            state_in      = STATE_RESET;
            held_valid_in = 1'b0;
         end else begin
            state_in      = state_mid;
            held_char_in  = req_tdata;
            held_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
      end
      held_char_ff <= held_char_in;
   end

   alt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .space_ok   (req_tready),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (rsp_res)
   );

   // Result packing
   assign rsp_tdata = {5'd0, rsp_res.status, rsp_res.empty_line, rsp_res.token_end,
                       rsp_res.operand_index, rsp_res.out_char};
   assign rsp_tuser = rsp_res.part;
   assign rsp_tlast = rsp_res.line_done;

   `ALT_ASSERT_NEXT(a_line_clear, accept && req_tlast, !held_valid_ff && (state_ff == STATE_RESET), "line state not cleared")
   `ALT_ASSERT_IMPL(a_drop_fields, rsp_tvalid && (rsp_tuser == PART_DROP), (rsp_tdata[14] == 1'b0) && (rsp_tdata[13:8] == 6'd0), "dropped char has token fields")
   `ALT_ASSERT_IMPL(a_empty_ok, rsp_tvalid && rsp_tdata[15], rsp_tlast && (rsp_tdata[18:16] == ERR_OK), "empty line flag off line end")

endmodule
